// File: rtl/frdt_pkg.sv
// frdt_pkg: shared types, codes and sizes of the fetch reorder and delay tracker
// no dependencies; used by the interfaces and every rtl module
package frdt_pkg;

    // pool geometry (power of two; slots are taken from the low id bits)
    localparam int POOL_DEPTH = 64;
    localparam int POOL_AW    = $clog2(POOL_DEPTH);
    localparam int CNT_W      = POOL_AW + 1;

    // field widths
    localparam int ID_W     = 16;
    localparam int TIME_W   = 32;
    localparam int DELAY_W  = 8;
    localparam int CREDIT_W = 6;
    localparam int FREE_W   = 7;
    localparam int CFG_W    = 8;

    typedef logic [1:0]          opcode_t;
    typedef logic [1:0]          status_t;
    typedef logic [1:0]          reg_index_t;
    typedef logic [ID_W-1:0]     id_t;
    typedef logic [TIME_W-1:0]   stamp_t;
    typedef logic [POOL_AW-1:0]  slot_t;
    typedef logic [CNT_W-1:0]    count_t;
    typedef logic [DELAY_W-1:0]  delay_t;
    typedef logic [CREDIT_W-1:0] credit_t;
    typedef logic [FREE_W-1:0]   free_t;
    typedef logic [CFG_W-1:0]    cfg_data_t;

    // command codes
    localparam opcode_t OP_ALLOC    = 2'd0;
    localparam opcode_t OP_COMPLETE = 2'd1;
    localparam opcode_t OP_ISSUE    = 2'd2;
    localparam opcode_t OP_RELEASE  = 2'd3;

    // result status codes
    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_NO_CREDIT = 2'd1;
    localparam status_t ST_NOT_READY = 2'd2;

    // configuration register indexes
    localparam reg_index_t REG_PIPE_DELAY = 2'd0;
    localparam reg_index_t REG_MAX_REQ    = 2'd1;
    localparam reg_index_t REG_POOL_SIZE  = 2'd2;

    // reset values and saturation limits
    localparam delay_t  PIPE_DELAY_RST = 8'd4;
    localparam credit_t MAX_REQ_RST    = 6'd8;
    localparam free_t   POOL_SIZE_RST  = 7'd16;
    localparam credit_t CREDIT_MAX     = 6'd63;
    localparam free_t   FREE_MAX       = 7'd127;

    // parked bucket payload
    typedef struct packed {
        logic   empty;
        stamp_t stamp;
    } park_entry_t;

    // issue queue payload
    typedef struct packed {
        id_t    id;
        stamp_t stamp;
    } queue_entry_t;

    // sequencer to park store
    typedef struct packed {
        logic   write;
        slot_t  write_slot;
        logic   empty;
        stamp_t stamp;
        logic   take;
        slot_t  probe_slot;
    } park_req_t;

    // park store to sequencer
    typedef struct packed {
        logic        hit;
        logic        any;
        park_entry_t entry;
    } park_stat_t;

    // sequencer to issue queue
    typedef struct packed {
        logic         push;
        queue_entry_t entry;
        logic         pop;
        logic         read;
    } queue_req_t;

    // issue queue to sequencer
    typedef struct packed {
        logic         nonempty;
        queue_entry_t head;
    } queue_stat_t;

endpackage

// File: rtl/frdt_if.sv
// frdt channel interfaces: command, result and configuration write channels
// depends on frdt_pkg
interface frdt_cmd_if;
    logic                 valid;
    logic                 ready;
    frdt_pkg::opcode_t    opcode;
    frdt_pkg::id_t        bucket_id;
    logic                 bucket_empty;
    frdt_pkg::stamp_t     now;

    modport source (output valid, opcode, bucket_id, bucket_empty, now, input ready);
    modport sink   (input valid, opcode, bucket_id, bucket_empty, now, output ready);
endinterface

interface frdt_res_if;
    logic                 valid;
    logic                 ready;
    frdt_pkg::status_t    status;
    frdt_pkg::id_t        result_id;
    logic                 outstanding;

    modport source (output valid, status, result_id, outstanding, input ready);
    modport sink   (input valid, status, result_id, outstanding, output ready);
endinterface

interface frdt_cfg_if;
    logic                   valid;
    logic                   ready;
    frdt_pkg::reg_index_t   index;
    frdt_pkg::cfg_data_t    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/fetch_reorder_delay_tracker.sv
// fetch_reorder_delay_tracker: top level, command sequencer, configuration and result register
// depends on frdt_pkg, frdt_if, frdt_park_store and frdt_issue_queue

// One command item is handled at a time by a small sequencer. Allocate, release and an issue
// that finds the queue empty pass from acceptance to result through accept, execute and load
// result. An issue against a non-empty queue adds a compare step, because the queue head comes
// out of a memory with a registered read before the ready-time compare. A complete that
// parks its bucket or falls outside the id window takes the same steps as an allocate. A
// complete of the next expected id adds, for every parked bucket it drains in sequence order,
// a probe of the present bit and then a read and release of the parked payload. The result
// sits in an output register: the next command is accepted while an earlier result waits to
// be taken, and that next command holds in its load step until the register is free.
// Configuration writes are taken whenever the sequencer is idle. Reset needs no clearing pass.
module fetch_reorder_delay_tracker (
    input  logic        clk,
    input  logic        rst_n,
    frdt_cmd_if.sink    cmd,
    frdt_res_if.source  res,
    frdt_cfg_if.sink    cfg
);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_EXEC      = 3'd1;
    localparam logic [2:0] S_DRAIN_CHK = 3'd2;
    localparam logic [2:0] S_DRAIN_REL = 3'd3;
    localparam logic [2:0] S_ISSUE_CMP = 3'd4;
    localparam logic [2:0] S_DONE      = 3'd5;

    localparam int RT_W = frdt_pkg::TIME_W + 1;

    logic [2:0]          state_reg,   state_next;
    frdt_pkg::opcode_t   op_reg,      op_next;
    frdt_pkg::id_t       bid_reg,     bid_next;
    logic                empty_reg,   empty_next;
    frdt_pkg::stamp_t    now_reg,     now_next;
    frdt_pkg::delay_t    delay_reg,   delay_next;
    frdt_pkg::credit_t   maxreq_reg,  maxreq_next;
    frdt_pkg::credit_t   credits_reg, credits_next;
    frdt_pkg::free_t     free_reg,    free_next;
    frdt_pkg::id_t       nalloc_reg,  nalloc_next;
    frdt_pkg::id_t       nexp_reg,    nexp_next;
    frdt_pkg::status_t   status_reg,  status_next;
    frdt_pkg::id_t       rid_reg,     rid_next;
    logic                outv_reg,    outv_next;
    frdt_pkg::status_t   ostat_reg,   ostat_next;
    frdt_pkg::id_t       orid_reg,    orid_next;
    logic                oout_reg,    oout_next;

    frdt_pkg::park_req_t   park_req;
    frdt_pkg::park_stat_t  park_stat;
    frdt_pkg::queue_req_t  queue_req;
    frdt_pkg::queue_stat_t queue_stat;

    logic                cmd_fire;
    logic                cfg_fire;
    logic                out_load;
    logic                rel_fire;
    logic                rel_empty;
    frdt_pkg::stamp_t    rel_stamp;
    logic                pool_ret;
    frdt_pkg::id_t       id_gap;
    logic [RT_W-1:0]     ready_time;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = (state_reg == S_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cfg_fire  = cfg.valid && cfg.ready;
    assign out_load  = (state_reg == S_DONE) && (!outv_reg || res.ready);

    // distance of the completed id from the next id expected in order
    assign id_gap = bid_reg - nexp_reg;

    // ready-time compare, without wrap
    assign ready_time = {1'b0, queue_stat.head.stamp}
                      + {{(RT_W - frdt_pkg::DELAY_W){1'b0}}, delay_reg};

    frdt_park_store u_park (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (park_req),
        .stat  (park_stat)
    );

    frdt_issue_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (queue_req),
        .stat  (queue_stat)
    );

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        bid_next     = bid_reg;
        empty_next   = empty_reg;
        now_next     = now_reg;
        delay_next   = delay_reg;
        maxreq_next  = maxreq_reg;
        credits_next = credits_reg;
        free_next    = free_reg;
        nalloc_next  = nalloc_reg;
        nexp_next    = nexp_reg;
        status_next  = status_reg;
        rid_next     = rid_reg;
        outv_next    = outv_reg;
        ostat_next   = ostat_reg;
        orid_next    = orid_reg;
        oout_next    = oout_reg;

        park_req            = '0;
        park_req.probe_slot = nexp_reg[frdt_pkg::POOL_AW-1:0];
        queue_req           = '0;
        rel_fire            = 1'b0;
        rel_empty           = empty_reg;
        rel_stamp           = now_reg;
        pool_ret            = 1'b0;

        // configuration writes
        if (cfg_fire)
        begin
            case (cfg.index)
                frdt_pkg::REG_PIPE_DELAY:
                begin
                    delay_next = cfg.data;
                end
                frdt_pkg::REG_MAX_REQ:
                begin
                    maxreq_next  = cfg.data[frdt_pkg::CREDIT_W-1:0];
                    credits_next = cfg.data[frdt_pkg::CREDIT_W-1:0];
                end
                frdt_pkg::REG_POOL_SIZE:
                begin
                    free_next = cfg.data[frdt_pkg::FREE_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_fire)
                begin
                    op_next     = cmd.opcode;
                    bid_next    = cmd.bucket_id;
                    empty_next  = cmd.bucket_empty;
                    now_next    = cmd.now;
                    status_next = frdt_pkg::ST_DONE;
                    rid_next    = '0;
                    state_next  = S_EXEC;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                unique case (op_reg)
                    frdt_pkg::OP_ALLOC:
                    begin
                        if (credits_reg == '0 || free_reg == '0)
                        begin
                            status_next = frdt_pkg::ST_NO_CREDIT;
                        end
                        else
                        begin
                            credits_next = credits_reg - 1'b1;
                            free_next    = free_reg - 1'b1;
                            rid_next     = nalloc_reg;
                            nalloc_next  = nalloc_reg + 1'b1;
                        end
                    end
                    frdt_pkg::OP_COMPLETE:
                    begin
                        if (credits_reg < frdt_pkg::CREDIT_MAX)
                        begin
                            credits_next = credits_reg + 1'b1;
                        end
                        if (id_gap == '0)
                        begin
                            rel_fire   = 1'b1;
                            state_next = S_DRAIN_CHK;
                        end
                        else if (id_gap < frdt_pkg::id_t'(frdt_pkg::POOL_DEPTH))
                        begin
                            park_req.write      = 1'b1;
                            park_req.write_slot = bid_reg[frdt_pkg::POOL_AW-1:0];
                            park_req.empty      = empty_reg;
                            park_req.stamp      = now_reg;
                        end
                    end
                    frdt_pkg::OP_ISSUE:
                    begin
                        if (!queue_stat.nonempty)
                        begin
                            status_next = frdt_pkg::ST_NOT_READY;
                        end
                        else
                        begin
                            queue_req.read = 1'b1;
                            state_next     = S_ISSUE_CMP;
                        end
                    end
                    frdt_pkg::OP_RELEASE:
                    begin
                        pool_ret = 1'b1;
                    end
                endcase
            end

            // probe the slot of the next expected id
            S_DRAIN_CHK:
            begin
                if (park_stat.hit)
                begin
                    park_req.take = 1'b1;
                    state_next    = S_DRAIN_REL;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // release the parked bucket just read
            S_DRAIN_REL:
            begin
                rel_fire   = 1'b1;
                rel_empty  = park_stat.entry.empty;
                rel_stamp  = park_stat.entry.stamp;
                state_next = S_DRAIN_CHK;
            end

            S_ISSUE_CMP:
            begin
                if (ready_time > {1'b0, now_reg})
                begin
                    status_next = frdt_pkg::ST_NOT_READY;
                end
                else
                begin
                    rid_next      = queue_stat.head.id;
                    queue_req.pop = 1'b1;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // in-order release of one bucket
        if (rel_fire)
        begin
            nexp_next = nexp_reg + 1'b1;
            if (rel_empty)
            begin
                pool_ret = 1'b1;
            end
            else
            begin
                queue_req.push        = 1'b1;
                queue_req.entry.id    = nexp_reg;
                queue_req.entry.stamp = rel_stamp;
            end
        end

        // bucket back to the free pool, saturating
        if (pool_ret && free_reg < frdt_pkg::FREE_MAX)
        begin
            free_next = free_reg + 1'b1;
        end

        // output register
        if (res.ready)
        begin
            outv_next = 1'b0;
        end
        if (out_load)
        begin
            outv_next  = 1'b1;
            ostat_next = status_reg;
            orid_next  = rid_reg;
            oout_next  = queue_stat.nonempty || park_stat.any || (credits_reg < maxreq_reg);
        end
    end

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            delay_reg   <= frdt_pkg::PIPE_DELAY_RST;
            maxreq_reg  <= frdt_pkg::MAX_REQ_RST;
            credits_reg <= frdt_pkg::MAX_REQ_RST;
            free_reg    <= frdt_pkg::POOL_SIZE_RST;
            nalloc_reg  <= '0;
            nexp_reg    <= '0;
            outv_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            delay_reg   <= delay_next;
            maxreq_reg  <= maxreq_next;
            credits_reg <= credits_next;
            free_reg    <= free_next;
            nalloc_reg  <= nalloc_next;
            nexp_reg    <= nexp_next;
            outv_reg    <= outv_next;
        end
    end

    // command and result payload
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        bid_reg    <= bid_next;
        empty_reg  <= empty_next;
        now_reg    <= now_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
        ostat_reg  <= ostat_next;
        orid_reg   <= orid_next;
        oout_reg   <= oout_next;
    end

    assign res.valid       = outv_reg;
    assign res.status      = ostat_reg;
    assign res.result_id   = orid_reg;
    assign res.outstanding = oout_reg;

    // a result is never produced without the command having been executed
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> ($past(state_reg) != S_IDLE))
        else $error("result stage entered straight from idle");

    // a parked payload is released only after a probe that hit
    a_drain_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN_REL) |->
            ($past(state_reg) == S_DRAIN_CHK && $past(park_stat.hit)))
        else $error("drain release without a present parked bucket");

    // loading a result frees the sequencer and shows the item from the output register
    a_load_shows_item: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (res.valid && state_reg == S_IDLE))
        else $error("loaded result not presented");

endmodule

// File: rtl/frdt_park_store.sv
// frdt_park_store: buckets that completed ahead of order, one slot per id window position
// present bits in flops, payload in a memory with registered read; depends on frdt_pkg
module frdt_park_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  frdt_pkg::park_req_t  req,
    output frdt_pkg::park_stat_t stat
);

    logic [frdt_pkg::POOL_DEPTH-1:0] present_reg;
    logic [frdt_pkg::POOL_DEPTH-1:0] present_next;
    frdt_pkg::count_t                cnt_reg;
    frdt_pkg::count_t                cnt_next;
    frdt_pkg::park_entry_t           mem [frdt_pkg::POOL_DEPTH];
    frdt_pkg::park_entry_t           rd_reg;

    // present bits and occupancy count
    always_comb
    begin
        present_next = present_reg;
        cnt_next     = cnt_reg;
        if (req.write)
        begin
            present_next[req.write_slot] = 1'b1;
            if (!present_reg[req.write_slot])
            begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
        if (req.take)
        begin
            present_next[req.probe_slot] = 1'b0;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            cnt_reg     <= '0;
        end
        else
        begin
            present_reg <= present_next;
            cnt_reg     <= cnt_next;
        end
    end

    // payload memory, overwritten in place on a repeated park
    always_ff @(posedge clk)
    begin
        if (req.write)
        begin
            mem[req.write_slot] <= '{empty: req.empty, stamp: req.stamp};
        end
        if (req.take)
        begin
            rd_reg <= mem[req.probe_slot];
        end
    end

    assign stat.hit   = present_reg[req.probe_slot];
    assign stat.any   = (cnt_reg != '0);
    assign stat.entry = rd_reg;

endmodule

// File: rtl/frdt_issue_queue.sv
// frdt_issue_queue: in-order fifo of released non-empty buckets waiting to issue
// circular memory with registered head read; depends on frdt_pkg
module frdt_issue_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  frdt_pkg::queue_req_t  req,
    output frdt_pkg::queue_stat_t stat
);

    frdt_pkg::slot_t        head_reg;
    frdt_pkg::slot_t        head_next;
    frdt_pkg::count_t       count_reg;
    frdt_pkg::count_t       count_next;
    frdt_pkg::slot_t        tail;
    logic                   full;
    logic                   do_push;
    frdt_pkg::queue_entry_t mem [frdt_pkg::POOL_DEPTH];
    frdt_pkg::queue_entry_t rd_reg;

    // tail wraps with the slot width
    assign tail    = head_reg + count_reg[frdt_pkg::POOL_AW-1:0];
    assign full    = (count_reg == frdt_pkg::count_t'(frdt_pkg::POOL_DEPTH));
    assign do_push = req.push && !full;

    // pointer and count update; a push into a full queue is dropped
    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (req.pop)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // entry memory
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[tail] <= req.entry;
        end
        if (req.read)
        begin
            rd_reg <= mem[head_reg];
        end
    end

    assign stat.nonempty = (count_reg != '0);
    assign stat.head     = rd_reg;

endmodule
